// File: rtl/rdns_pkg.sv
`default_nettype none

package rdns_pkg;

   // Fixed widths of the transaction fields and the register port.
   localparam int FIELD_W    = 11;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // The alive map is held as words of this many positions.
   localparam int WORD_BITS = 64;
   localparam int BIT_IDX_W = 6;

   // Request operation codes.
   localparam logic FUNC_RESTART = 1'b0;
   localparam logic FUNC_RANGE   = 1'b1;

   // Register index, taken from the word-aligned address bit.
   localparam logic CSR_SOLDIER_COUNT = 1'b0;

   localparam logic [FIELD_W-1:0] SOLDIER_COUNT_RESET = 11'd1024;

   // Index of the highest set bit (zero when none is set).
   function automatic logic [BIT_IDX_W-1:0] msb_index(input logic [WORD_BITS-1:0] w);
      logic [BIT_IDX_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (w[i]) begin
            idx = BIT_IDX_W'(i);
         end
      end
      return idx;
   endfunction

   // Index of the lowest set bit (zero when none is set).
   function automatic logic [BIT_IDX_W-1:0] lsb_index(input logic [WORD_BITS-1:0] w);
      logic [BIT_IDX_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (w[i]) begin
            idx = BIT_IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// File: rtl/range_delete_nearest_survivors.sv
`default_nettype none
// Range delete with nearest survivors.
// The block keeps a line of positions 1..MAX_POSITIONS, each alive or removed.
// Request channel (req_*): a restart transaction (func 0) makes positions 1 up to
// soldier_count alive and gives no response. A range transaction (func 1) removes
// the alive positions from left_end to right_end and gives one response with the
// nearest alive position on either side, or all zeros if nothing was removed.
// Response channel (rsp_*): one registered transaction per range request.
// The APB-style port holds soldier_count at address 0; write it only while idle.
// Storage: the map lives in a single-port memory of 64-position words. A restart
// writes its W = MAX_POSITIONS/64+1 words in turn. A range request reads and
// rewrites each word spanned by the range, then reads and checks each word
// scanned down and up to the nearest survivors.
// A new request is taken only when the sequencer is idle.
// Reset clears the map (through a loaded flag, without a sweep), empties the
// response register and sets soldier_count to 1024. A stalled response holds;
// the block then finishes the next request and waits before the output stage.

module range_delete_nearest_survivors
   import rdns_pkg::*;
#(
   parameter int MAX_POSITIONS = 1024
) (
   input  wire                     clock,
   input  wire                     reset,
   // request channel
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire                     req_func,
   input  wire  [FIELD_W-1:0]      req_left_end,
   input  wire  [FIELD_W-1:0]      req_right_end,
   // response channel
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output logic                    rsp_left_valid,
   output logic [FIELD_W-1:0]      rsp_left_survivor,
   output logic                    rsp_right_valid,
   output logic [FIELD_W-1:0]      rsp_right_survivor,
   // configuration port
   input  wire                     psel,
   input  wire                     penable,
   input  wire                     pwrite,
   input  wire  [CSR_ADDR_W-1:0]   paddr,
   input  wire  [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready
);

   // Word count covers positions 0..MAX_POSITIONS; position 0 is never alive.
   localparam int WordCnt = MAX_POSITIONS / WORD_BITS + 1;
   localparam int WaW     = (WordCnt > 1) ? $clog2(WordCnt) : 1;
   localparam int PW      = WaW + BIT_IDX_W;
   localparam int XW      = (PW > FIELD_W) ? PW : FIELD_W;
   localparam logic [WaW-1:0] LastWord = WaW'(WordCnt - 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_FILL   = 4'd1;
   localparam logic [3:0] ST_RM_RD  = 4'd2;
   localparam logic [3:0] ST_RM_WR  = 4'd3;
   localparam logic [3:0] ST_LS_RD  = 4'd4;
   localparam logic [3:0] ST_LS_CHK = 4'd5;
   localparam logic [3:0] ST_RS_RD  = 4'd6;
   localparam logic [3:0] ST_RS_CHK = 4'd7;
   localparam logic [3:0] ST_EMIT   = 4'd8;

   // Control state.
   logic [3:0]         state_ff, state_in;
   logic               loaded_ff, loaded_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] sc_ff, sc_in;

   // Working registers of the sequencer.
   logic [WaW-1:0]     word_ff, word_in;
   logic [PW-1:0]      start_ff, start_in;
   logic [PW-1:0]      stop_ff, stop_in;
   logic [PW-1:0]      nlim_ff, nlim_in;
   logic               removed_ff, removed_in;
   logic               lv_ff, lv_in;
   logic [PW-1:0]      ls_ff, ls_in;
   logic               rv_ff, rv_in;
   logic [PW-1:0]      rs_ff, rs_in;

   // Response payload.
   logic               rsp_lv_ff, rsp_rv_ff;
   logic [FIELD_W-1:0] rsp_ls_ff, rsp_rs_ff;

   // Alive-map memory.
   logic [WORD_BITS-1:0] alive_mem_ff [WordCnt];
   logic [WORD_BITS-1:0] rdata_ff;
   logic                 mem_we;
   logic [WaW-1:0]       mem_addr;
   logic [WORD_BITS-1:0] mem_wdata;

   // Datapath helpers.
   logic                 req_accept;
   logic                 emit_load;
   logic                 csr_write;
   logic [XW-1:0]        lo_x, hi_x, max_x, sc_x, start_x, stop_x, n_x;
   logic [WORD_BITS-1:0] word_data;
   logic [WORD_BITS-1:0] rm_mask, fill_mask, left_mask, right_mask;
   logic [WORD_BITS-1:0] rm_hit, left_hit, right_hit;
   logic [BIT_IDX_W-1:0] rm_lo_b, rm_hi_b;

   logic [WaW-1:0]       start_word, stop_word, nlim_word;
   logic [BIT_IDX_W-1:0] start_bit, stop_bit, nlim_bit;

   assign start_word = start_ff[PW-1:BIT_IDX_W];
   assign stop_word  = stop_ff[PW-1:BIT_IDX_W];
   assign nlim_word  = nlim_ff[PW-1:BIT_IDX_W];
   assign start_bit  = start_ff[BIT_IDX_W-1:0];
   assign stop_bit   = stop_ff[BIT_IDX_W-1:0];
   assign nlim_bit   = nlim_ff[BIT_IDX_W-1:0];

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign emit_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[CSR_ADDR_W-1] == CSR_SOLDIER_COUNT) ? CSR_DATA_W'(sc_ff) : '0;

   // Request bounds are clipped to the line before they are stored.
   assign lo_x    = XW'(req_left_end);
   assign hi_x    = XW'(req_right_end);
   assign max_x   = XW'(MAX_POSITIONS);
   assign sc_x    = XW'(sc_ff);
   assign start_x = (lo_x == '0) ? XW'(1) : lo_x;
   assign stop_x  = (hi_x > max_x) ? max_x : hi_x;
   assign n_x     = (sc_x > max_x) ? max_x : sc_x;

   // Before the first restart the memory holds nothing meaningful and reads as empty.
   assign word_data = loaded_ff ? rdata_ff : '0;

   assign rm_lo_b = (word_ff == start_word) ? start_bit : '0;
   assign rm_hi_b = (word_ff == stop_word) ? stop_bit : '1;

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         rm_mask[b]    = (BIT_IDX_W'(b) >= rm_lo_b) && (BIT_IDX_W'(b) <= rm_hi_b);
         left_mask[b]  = (word_ff != start_word) || (BIT_IDX_W'(b) < start_bit);
         right_mask[b] = (word_ff != stop_word) || (BIT_IDX_W'(b) > stop_bit);
         if (word_ff < nlim_word) begin
            fill_mask[b] = 1'b1;
         end else if (word_ff == nlim_word) begin
            fill_mask[b] = (BIT_IDX_W'(b) <= nlim_bit);
         end else begin
            fill_mask[b] = 1'b0;
         end
      end
      // Position zero is never alive.
      if (word_ff == '0) begin
         fill_mask[0] = 1'b0;
      end
   end

   assign rm_hit    = word_data & rm_mask;
   assign left_hit  = word_data & left_mask;
   assign right_hit = word_data & right_mask;

   // Sequencer: one memory word is read, then checked or rewritten; a restart only writes.
   always_comb begin
      state_in   = state_ff;
      loaded_in  = loaded_ff;
      word_in    = word_ff;
      start_in   = start_ff;
      stop_in    = stop_ff;
      nlim_in    = nlim_ff;
      removed_in = removed_ff;
      lv_in      = lv_ff;
      ls_in      = ls_ff;
      rv_in      = rv_ff;
      rs_in      = rs_ff;
      mem_we     = 1'b0;
      mem_addr   = word_ff;
      mem_wdata  = fill_mask;
      sc_in      = sc_ff;

      if (csr_write && (paddr[CSR_ADDR_W-1] == CSR_SOLDIER_COUNT)) begin
         sc_in = pwdata[FIELD_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               removed_in = 1'b0;
               lv_in      = 1'b0;
               ls_in      = '0;
               rv_in      = 1'b0;
               rs_in      = '0;
               start_in   = PW'(start_x);
               stop_in    = PW'(stop_x);
               if (req_func == FUNC_RESTART) begin
                  nlim_in  = PW'(n_x);
                  word_in  = '0;
                  state_in = ST_FILL;
               end else if (start_x > stop_x) begin
                  state_in = ST_EMIT;
               end else begin
                  word_in  = start_x[PW-1:BIT_IDX_W];
                  state_in = ST_RM_RD;
               end
            end
         end
         ST_FILL: begin
            mem_we = 1'b1;
            if (word_ff == LastWord) begin
               loaded_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               word_in = word_ff + WaW'(1);
            end
         end
         ST_RM_RD: begin
            state_in = ST_RM_WR;
         end
         ST_RM_WR: begin
            mem_we     = loaded_ff;
            mem_wdata  = word_data & ~rm_mask;
            removed_in = removed_ff || (rm_hit != '0);
            if (word_ff == stop_word) begin
               word_in  = start_word;
               state_in = removed_in ? ST_LS_RD : ST_EMIT;
            end else begin
               word_in  = word_ff + WaW'(1);
               state_in = ST_RM_RD;
            end
         end
         ST_LS_RD: begin
            state_in = ST_LS_CHK;
         end
         ST_LS_CHK: begin
            if (left_hit != '0) begin
               lv_in    = 1'b1;
               ls_in    = {word_ff, msb_index(left_hit)};
               word_in  = stop_word;
               state_in = ST_RS_RD;
            end else if (word_ff == '0) begin
               word_in  = stop_word;
               state_in = ST_RS_RD;
            end else begin
               word_in  = word_ff - WaW'(1);
               state_in = ST_LS_RD;
            end
         end
         ST_RS_RD: begin
            state_in = ST_RS_CHK;
         end
         ST_RS_CHK: begin
            if (right_hit != '0) begin
               rv_in    = 1'b1;
               rs_in    = {word_ff, lsb_index(right_hit)};
               state_in = ST_EMIT;
            end else if (word_ff == LastWord) begin
               state_in = ST_EMIT;
            end else begin
               word_in  = word_ff + WaW'(1);
               state_in = ST_RS_RD;
            end
         end
         ST_EMIT: begin
            if (emit_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loaded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sc_ff        <= SOLDIER_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         rsp_valid_ff <= rsp_valid_in;
         sc_ff        <= sc_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff    <= word_in;
      start_ff   <= start_in;
      stop_ff    <= stop_in;
      nlim_ff    <= nlim_in;
      removed_ff <= removed_in;
      lv_ff      <= lv_in;
      ls_ff      <= ls_in;
      rv_ff      <= rv_in;
      rs_ff      <= rs_in;
      if (emit_load) begin
         rsp_lv_ff <= lv_ff;
         rsp_ls_ff <= FIELD_W'(ls_ff);
         rsp_rv_ff <= rv_ff;
         rsp_rs_ff <= FIELD_W'(rs_ff);
      end
   end

   // Single-port word memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         alive_mem_ff[mem_addr] <= mem_wdata;
      end
      rdata_ff <= alive_mem_ff[mem_addr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_valid     = rsp_lv_ff;
   assign rsp_left_survivor  = rsp_ls_ff;
   assign rsp_right_valid    = rsp_rv_ff;
   assign rsp_right_survivor = rsp_rs_ff;

   // The map is only written by the restart sweep or the removal pass.
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_FILL || state_ff == ST_RM_WR))
      else $error("alive map written outside a fill or removal step");

   // An accepted request always starts work, so the next one waits.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE))
      else $error("sequencer stayed idle after taking a request");

   // A new response only appears after the emit step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT))
      else $error("response raised without an emit step");

   // A missing survivor is reported as position zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_left_valid) |-> (rsp_left_survivor == '0))
      else $error("left survivor not zero while flagged invalid");

endmodule

`default_nettype wire
